// ===== sv/slex_pkg.sv =====
// ----------------------------------------------------------------------------
// Script lexer package
// Shared types, character and token codes, and the per-character helper
// functions of the script lexer.
// ----------------------------------------------------------------------------
package slex_pkg;

  localparam int LINE_BITS = 16;
  localparam int CHAR_BITS = 8;
  localparam int KIND_BITS = 6;
  // Stream data widths, rounded up to whole bytes.
  localparam int S_DATA_W  = ((CHAR_BITS + LINE_BITS + 7) / 8) * 8;
  localparam int M_DATA_W  = ((CHAR_BITS + LINE_BITS + 7) / 8) * 8;
  localparam int M_USER_W  = 1 + KIND_BITS;

  // Lexer modes.
  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_COMMENT = 3'd1;
  localparam logic [2:0] M_OPHELD  = 3'd2;
  localparam logic [2:0] M_NUM     = 3'd3;
  localparam logic [2:0] M_NUMBAD  = 3'd4;
  localparam logic [2:0] M_STR     = 3'd5;
  localparam logic [2:0] M_ESC     = 3'd6;
  localparam logic [2:0] M_WORD    = 3'd7;

  // Token kinds: operators first.
  localparam logic [5:0] OP_LBRACE = 6'd0;
  localparam logic [5:0] OP_RBRACE = 6'd1;
  localparam logic [5:0] OP_LPAREN = 6'd2;
  localparam logic [5:0] OP_RPAREN = 6'd3;
  localparam logic [5:0] OP_COMMA  = 6'd4;
  localparam logic [5:0] OP_SEMI   = 6'd5;
  localparam logic [5:0] OP_ASSIGN = 6'd6;
  localparam logic [5:0] OP_PLUS   = 6'd7;
  localparam logic [5:0] OP_MINUS  = 6'd8;
  localparam logic [5:0] OP_STAR   = 6'd9;
  localparam logic [5:0] OP_SLASH  = 6'd10;
  localparam logic [5:0] OP_PCT    = 6'd11;
  localparam logic [5:0] OP_AMP    = 6'd12;
  localparam logic [5:0] OP_BAR    = 6'd13;
  localparam logic [5:0] OP_BANG   = 6'd14;
  localparam logic [5:0] OP_CARET  = 6'd15;
  localparam logic [5:0] OP_LT     = 6'd16;
  localparam logic [5:0] OP_GT     = 6'd17;
  localparam logic [5:0] OP_EQEQ   = 6'd18;
  localparam logic [5:0] OP_NE     = 6'd19;
  localparam logic [5:0] OP_SHL    = 6'd20;
  localparam logic [5:0] OP_SHR    = 6'd21;
  localparam logic [5:0] OP_GE     = 6'd22;
  localparam logic [5:0] OP_LE     = 6'd23;
  localparam logic [5:0] OP_LAND   = 6'd24;
  localparam logic [5:0] OP_LOR    = 6'd25;
  localparam logic [5:0] K_INT     = 6'd26;
  localparam logic [5:0] K_FLOAT   = 6'd27;
  localparam logic [5:0] K_STRING  = 6'd28;
  localparam logic [5:0] K_BOOL    = 6'd29;
  localparam logic [5:0] K_WORD    = 6'd30;
  localparam logic [5:0] K_NULL    = 6'd31;
  localparam logic [5:0] K_NUMERR  = 6'd32;
  localparam logic [5:0] K_UNTERM  = 6'd33;

  // Characters with a special role.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_X      = 8'h78;

  typedef struct packed {
    logic [CHAR_BITS-1:0] chr;
    logic                 cvalid;
    logic                 last;
    logic [KIND_BITS-1:0] kind;
    logic [LINE_BITS-1:0] line;
  } slex_res_t;

  typedef struct packed {
    logic [2:0]           mode;
    logic [CHAR_BITS-1:0] held;
    logic [LINE_BITS-1:0] start_line;
    logic                 dot;
    logic [2:0]           wcount;
    logic [1:0]           kmatch;   // bit 0: may be true, bit 1: may be false
  } slex_state_t;

  // Results of one character, first result in entry 0.
  typedef struct packed {
    logic [1:0]           cnt;
    slex_res_t [2:0]      res;
  } slex_batch_t;

  typedef struct packed {
    logic        emit;
    slex_res_t   res;
    slex_state_t st;
  } slex_begin_t;

  function automatic slex_res_t mk_res(logic [7:0] ch, logic cv, logic last,
                                       logic [5:0] kind, logic [LINE_BITS-1:0] line);
    slex_res_t r;
    r.chr    = ch;
    r.cvalid = cv;
    r.last   = last;
    r.kind   = last ? kind : '0;
    r.line   = line;
    return r;
  endfunction

  // Returns {hit, code}.
  function automatic logic [6:0] single_code(logic [7:0] c);
    logic [6:0] r;
    r = '0;
    case (c)
      8'h7B: r = {1'b1, OP_LBRACE};
      8'h7D: r = {1'b1, OP_RBRACE};
      8'h28: r = {1'b1, OP_LPAREN};
      8'h29: r = {1'b1, OP_RPAREN};
      8'h2C: r = {1'b1, OP_COMMA};
      8'h3B: r = {1'b1, OP_SEMI};
      8'h3D: r = {1'b1, OP_ASSIGN};
      8'h2B: r = {1'b1, OP_PLUS};
      8'h2D: r = {1'b1, OP_MINUS};
      8'h2A: r = {1'b1, OP_STAR};
      8'h2F: r = {1'b1, OP_SLASH};
      8'h25: r = {1'b1, OP_PCT};
      8'h26: r = {1'b1, OP_AMP};
      8'h7C: r = {1'b1, OP_BAR};
      8'h21: r = {1'b1, OP_BANG};
      8'h5E: r = {1'b1, OP_CARET};
      8'h3C: r = {1'b1, OP_LT};
      8'h3E: r = {1'b1, OP_GT};
      default: r = '0;
    endcase
    return r;
  endfunction

  // Returns {hit, code} for a two-character operator.
  function automatic logic [6:0] double_code(logic [7:0] a, logic [7:0] b);
    logic [6:0] r;
    r = '0;
    case ({a, b})
      16'h3D3D: r = {1'b1, OP_EQEQ};
      16'h213D: r = {1'b1, OP_NE};
      16'h3C3C: r = {1'b1, OP_SHL};
      16'h3E3E: r = {1'b1, OP_SHR};
      16'h3E3D: r = {1'b1, OP_GE};
      16'h3C3D: r = {1'b1, OP_LE};
      16'h2626: r = {1'b1, OP_LAND};
      16'h7C7C: r = {1'b1, OP_LOR};
      default:  r = '0;
    endcase
    return r;
  endfunction

  function automatic logic may_pair(logic [7:0] c);
    return (c == 8'h3D) || (c == 8'h21) || (c == 8'h3C) || (c == 8'h3E) ||
           (c == 8'h26) || (c == 8'h7C);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_numeric(logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_MINUS) || (c == CH_X) ||
           (c == CH_DOT);
  endfunction

  // Returns {hit, replacement}.
  function automatic logic [8:0] escape_of(logic [7:0] c);
    logic [8:0] r;
    r = '0;
    case (c)
      CH_BSLASH: r = {1'b1, CH_BSLASH};
      CH_N:      r = {1'b1, CH_LF};
      CH_T:      r = {1'b1, CH_TAB};
      CH_DQUOTE: r = {1'b1, CH_DQUOTE};
      CH_SQUOTE: r = {1'b1, CH_SQUOTE};
      default:   r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_true_ch(logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0:    r = 8'h74;  // t
      2'd1:    r = 8'h72;  // r
      2'd2:    r = 8'h75;  // u
      default: r = 8'h65;  // e
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_false_ch(logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = 8'h66;  // f
      3'd1:    r = 8'h61;  // a
      3'd2:    r = 8'h6C;  // l
      3'd3:    r = 8'h73;  // s
      default: r = 8'h65;  // e
    endcase
    return r;
  endfunction

  function automatic slex_state_t word_track(slex_state_t s, logic [7:0] c);
    slex_state_t n;
    n = s;
    if ((s.wcount >= 3'd4) || (kw_true_ch(s.wcount[1:0]) != c)) begin
      n.kmatch[0] = 1'b0;
    end
    if ((s.wcount >= 3'd5) ||
        (kw_false_ch((s.wcount < 3'd5) ? s.wcount : 3'd0) != c)) begin
      n.kmatch[1] = 1'b0;
    end
    if (s.wcount < 3'd7) begin
      n.wcount = s.wcount + 3'd1;
    end
    return n;
  endfunction

  function automatic logic [5:0] word_kind(slex_state_t s);
    if ((s.kmatch[0] && (s.wcount == 3'd4)) || (s.kmatch[1] && (s.wcount == 3'd5))) begin
      return K_BOOL;
    end
    return K_WORD;
  endfunction

  function automatic slex_state_t go_idle(slex_state_t s);
    slex_state_t n;
    n        = s;
    n.mode   = M_IDLE;
    n.held   = '0;
    n.dot    = 1'b0;
    n.wcount = '0;
    n.kmatch = 2'b11;
    return n;
  endfunction

  // Handles a character seen at a token boundary.
  function automatic slex_begin_t begin_tok(slex_state_t s, logic [7:0] c, logic le,
                                            logic [LINE_BITS-1:0] line);
    slex_begin_t b;
    logic [6:0]  sc;
    b.emit = 1'b0;
    b.res  = '0;
    b.st   = s;
    sc     = single_code(c);
    if (c == CH_NUL) begin
      b.emit          = 1'b1;
      b.res           = mk_res(CH_NUL, 1'b0, 1'b1, K_NULL, '1);
      b.st            = go_idle(s);
      b.st.start_line = '0;
    end else if (is_space(c)) begin
      b.st = s;
    end else if (c == CH_HASH) begin
      if (!le) begin
        b.st.mode = M_COMMENT;
      end
    end else begin
      b.st.start_line = line;
      if (sc[6]) begin
        if (may_pair(c)) begin
          b.st.mode = M_OPHELD;
          b.st.held = c;
        end else begin
          b.emit = 1'b1;
          b.res  = mk_res(c, 1'b1, 1'b1, sc[5:0], line);
        end
      end else if (is_numeric(c)) begin
        b.st.mode = M_NUM;
        b.st.dot  = (c == CH_DOT);
        b.emit    = 1'b1;
        b.res     = mk_res(c, 1'b1, 1'b0, '0, line);
      end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
        b.st.mode = M_STR;
        b.st.held = c;
      end else begin
        b.st.mode   = M_WORD;
        b.st.wcount = '0;
        b.st.kmatch = 2'b11;
        b.st        = word_track(b.st, c);
        b.emit      = 1'b1;
        b.res       = mk_res(c, 1'b1, 1'b0, '0, line);
      end
    end
    return b;
  endfunction

endpackage

// ===== sv/slex_step.sv =====
// ----------------------------------------------------------------------------
// Script lexer step
// Holds the lexer state and works out, for one character, the next state and
// the up to three result items that the character produces.
// ----------------------------------------------------------------------------
module slex_step
  import slex_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic [7:0]           char_code_i,
  input  logic                 line_end_i,
  input  logic                 source_end_i,
  input  logic [LINE_BITS-1:0] line_number_i,
  output slex_batch_t          batch_o
);

  slex_state_t     state_q, state_d;
  slex_res_t [2:0] r;
  logic [1:0]      n;
  slex_begin_t     bg;
  logic [6:0]      sc_held;
  logic [6:0]      sc_c;
  logic [6:0]      dc;
  logic [8:0]      esc;
  logic [7:0]      c;

  assign c       = char_code_i;
  assign sc_held = single_code(state_q.held);
  assign sc_c    = single_code(c);
  assign dc      = double_code(state_q.held, c);
  assign esc     = escape_of(c);

  always_comb begin
    state_d = state_q;
    r       = '0;
    n       = '0;
    bg      = '0;
    if (source_end_i) begin
      // Close whatever token is open, then send the null token.
      unique case (state_q.mode)
        M_OPHELD: begin
          r[n] = mk_res(state_q.held, 1'b1, 1'b1, sc_held[5:0], state_q.start_line);
          n    = n + 2'd1;
        end
        M_NUM: begin
          r[n] = mk_res(CH_NUL, 1'b0, 1'b1, state_q.dot ? K_FLOAT : K_INT,
                        state_q.start_line);
          n    = n + 2'd1;
        end
        M_NUMBAD: begin
          r[n] = mk_res(CH_NUL, 1'b0, 1'b1, K_NUMERR, state_q.start_line);
          n    = n + 2'd1;
        end
        M_ESC: begin
          r[n] = mk_res(CH_BSLASH, 1'b1, 1'b0, '0, state_q.start_line);
          n    = n + 2'd1;
          r[n] = mk_res(CH_NUL, 1'b0, 1'b1, K_UNTERM, state_q.start_line);
          n    = n + 2'd1;
        end
        M_STR: begin
          r[n] = mk_res(CH_NUL, 1'b0, 1'b1, K_UNTERM, state_q.start_line);
          n    = n + 2'd1;
        end
        M_WORD: begin
          r[n] = mk_res(CH_NUL, 1'b0, 1'b1, word_kind(state_q), state_q.start_line);
          n    = n + 2'd1;
        end
        default: begin
          n = n;
        end
      endcase
      r[n]               = mk_res(CH_NUL, 1'b0, 1'b1, K_NULL, '1);
      n                  = n + 2'd1;
      state_d            = go_idle(state_q);
      state_d.start_line = '0;
    end else begin
      unique case (state_q.mode)
        M_IDLE: begin
          bg = begin_tok(state_q, c, line_end_i, line_number_i);
          if (bg.emit) begin
            r[n] = bg.res;
            n    = n + 2'd1;
          end
          state_d = bg.st;
        end
        M_COMMENT: begin
          if (line_end_i) begin
            state_d.mode = M_IDLE;
          end
        end
        M_OPHELD: begin
          if (dc[6]) begin
            r[n]    = mk_res(state_q.held, 1'b1, 1'b0, '0, state_q.start_line);
            n       = n + 2'd1;
            r[n]    = mk_res(c, 1'b1, 1'b1, dc[5:0], state_q.start_line);
            n       = n + 2'd1;
            state_d = go_idle(state_q);
          end else begin
            r[n] = mk_res(state_q.held, 1'b1, 1'b1, sc_held[5:0], state_q.start_line);
            n    = n + 2'd1;
            bg   = begin_tok(go_idle(state_q), c, line_end_i, line_number_i);
            if (bg.emit) begin
              r[n] = bg.res;
              n    = n + 2'd1;
            end
            state_d = bg.st;
          end
        end
        M_NUM, M_NUMBAD: begin
          if (is_numeric(c)) begin
            if (c == CH_DOT) begin
              if (state_q.dot) begin
                state_d.mode = M_NUMBAD;
              end
              state_d.dot = 1'b1;
            end
            r[n] = mk_res(c, 1'b1, 1'b0, '0, state_q.start_line);
            n    = n + 2'd1;
          end else begin
            r[n] = mk_res(CH_NUL, 1'b0, 1'b1,
                          (state_q.mode == M_NUMBAD) ? K_NUMERR :
                          (state_q.dot ? K_FLOAT : K_INT), state_q.start_line);
            n    = n + 2'd1;
            bg   = begin_tok(go_idle(state_q), c, line_end_i, line_number_i);
            if (bg.emit) begin
              r[n] = bg.res;
              n    = n + 2'd1;
            end
            state_d = bg.st;
          end
        end
        M_STR, M_ESC: begin
          state_d.mode = M_STR;
          if ((state_q.mode == M_ESC) && esc[8]) begin
            r[n] = mk_res(esc[7:0], 1'b1, 1'b0, '0, state_q.start_line);
            n    = n + 2'd1;
          end else begin
            // A backslash that escapes nothing is kept as text.
            if (state_q.mode == M_ESC) begin
              r[n] = mk_res(CH_BSLASH, 1'b1, 1'b0, '0, state_q.start_line);
              n    = n + 2'd1;
            end
            if (c == state_q.held) begin
              r[n]    = mk_res(CH_NUL, 1'b0, 1'b1, K_STRING, state_q.start_line);
              n       = n + 2'd1;
              state_d = go_idle(state_q);
            end else if (c == CH_BSLASH) begin
              state_d.mode = M_ESC;
            end else begin
              r[n] = mk_res(c, 1'b1, 1'b0, '0, state_q.start_line);
              n    = n + 2'd1;
            end
          end
        end
        default: begin
          // Inside a word.
          if (is_space(c) || (c == CH_HASH) || (c == CH_NUL) || sc_c[6]) begin
            r[n] = mk_res(CH_NUL, 1'b0, 1'b1, word_kind(state_q), state_q.start_line);
            n    = n + 2'd1;
            bg   = begin_tok(go_idle(state_q), c, line_end_i, line_number_i);
            if (bg.emit) begin
              r[n] = bg.res;
              n    = n + 2'd1;
            end
            state_d = bg.st;
          end else begin
            state_d = word_track(state_q, c);
            r[n]    = mk_res(c, 1'b1, 1'b0, '0, state_q.start_line);
            n       = n + 2'd1;
          end
        end
      endcase
    end
  end

  assign batch_o.cnt = n;
  assign batch_o.res = r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{mode: M_IDLE, held: '0, start_line: '0, dot: 1'b0, wcount: '0,
                   kmatch: 2'b11};
    end else if (take_i) begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/slex_obuf.sv =====
// ----------------------------------------------------------------------------
// Script lexer result buffer
// Holds the results of one character and hands them out one per transaction.
// ----------------------------------------------------------------------------
module slex_obuf
  import slex_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  slex_batch_t batch_i,
  input  logic        pop_ready_i,
  output logic        can_load_o,
  output logic        head_valid_o,
  output slex_res_t   head_o
);

  slex_res_t [2:0] slot_q, slot_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            pop;

  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = slot_q[0];
  assign pop          = head_valid_o && pop_ready_i;
  // A new batch may come in once the last waiting result leaves this cycle.
  assign can_load_o   = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop_ready_i);

  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (load_i) begin
      slot_d = batch_i.res;
      cnt_d  = batch_i.cnt;
    end else if (pop) begin
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
      cnt_d     = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

// ===== sv/script_lexer_core.sv =====
// ----------------------------------------------------------------------------
// Script lexer core
// Streaming lexer that turns source characters into token result items.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel carries one source character per transaction, with its
// line number, a line-end mark on tlast and an end-of-source flag on tuser.
// The master channel carries one result item per transaction: a token
// character, its valid flag and the token kind, with tlast on the final
// item of each token.
// Each accepted character is handled in the cycle it arrives; its results
// (zero to three) sit in a result register and appear in the next cycle.
// Throughput is one character per cycle while each character yields at most
// one result and the receiver is ready. A character with more results holds
// the input while the result register drains them, one item per cycle.
// Reset returns the lexer to its idle state and empties the result register.
// When the receiver stalls, the waiting result holds steady; the input is
// still taken in the cycle in which the last waiting result leaves.
// ----------------------------------------------------------------------------
module script_lexer_core
  import slex_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // Bits from low: char_code[7:0], line_number[LINE_BITS-1:0].
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,
  // line_end: last character of its source line.
  input  logic                s_axis_tlast_i,
  // source_end: end of the source, no character carried.
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // Bits from low: token_char[7:0], token_line[LINE_BITS-1:0].
  output logic [M_DATA_W-1:0] m_axis_tdata_o,
  // token_last: final result of a token.
  output logic                m_axis_tlast_o,
  // Bits from low: char_valid, token_kind[5:0].
  output logic [M_USER_W-1:0] m_axis_tuser_o
);

  logic        take;
  logic        can_load;
  slex_batch_t batch;
  slex_res_t   head;

  // A character transaction completes only when the buffer can take its batch.
  assign s_axis_tready_o = can_load;
  assign take            = s_axis_tvalid_i && can_load;

  slex_step u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .char_code_i   (s_axis_tdata_i[7:0]),
    .line_end_i    (s_axis_tlast_i),
    .source_end_i  (s_axis_tuser_i),
    .line_number_i (s_axis_tdata_i[CHAR_BITS +: LINE_BITS]),
    .batch_o       (batch)
  );

  slex_obuf u_obuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (take),
    .batch_i      (batch),
    .pop_ready_i  (m_axis_tready_i),
    .can_load_o   (can_load),
    .head_valid_o (m_axis_tvalid_o),
    .head_o       (head)
  );

  assign m_axis_tdata_o = M_DATA_W'({head.line, head.chr});
  assign m_axis_tlast_o = head.last;
  assign m_axis_tuser_o = {head.kind, head.cvalid};

endmodule

// ===== sv/slex_checker.sv =====
// ----------------------------------------------------------------------------
// Script lexer checker
// Port-level assertions on the lexer core, attached by bind.
// ----------------------------------------------------------------------------
module slex_checker
  import slex_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_tvalid_i,
  input logic                s_tready_i,
  input logic                m_tvalid_i,
  input logic                m_tready_i,
  input logic [M_DATA_W-1:0] m_tdata_i,
  input logic                m_tlast_i,
  input logic [M_USER_W-1:0] m_tuser_i
);

  // A stalled result transaction holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) &&
    $stable(m_tlast_i) && $stable(m_tuser_i))
    else $error("stalled result changed");

  // The input is held off only while results are still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_i |-> m_tvalid_i)
    else $error("input blocked with no result pending");

  // An item without a character is always the end marker of a token.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tuser_i[0] |-> m_tlast_i)
    else $error("characterless item is not a token end");

  // Items inside a token carry kind zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tlast_i |-> m_tuser_i[M_USER_W-1:1] == '0)
    else $error("kind set on a non-final item");

  // The null token reports the all-ones line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tlast_i && (m_tuser_i[M_USER_W-1:1] == K_NULL) |->
    m_tdata_i[CHAR_BITS +: LINE_BITS] == '1)
    else $error("null token line is not all ones");

endmodule

bind script_lexer_core slex_checker u_slex_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tlast_i  (m_axis_tlast_o),
  .m_tuser_i  (m_axis_tuser_o)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Script lexer core testbench
// Streams source characters into the lexer and checks every token result
// item against a cycle-free model of the lexer that runs on each accepted
// character. Stimulus is a short directed sequence followed by random
// sources and noise under three idling profiles and one long receiver stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import slex_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int HOLD_CYCLES = 120;

  // One source character as it travels on the slave channel.
  typedef struct {
    logic [7:0]           chr;
    logic                 le;
    logic                 se;
    logic [LINE_BITS-1:0] line;
  } src_char_t;

  // One token result item as it travels on the master channel.
  typedef struct packed {
    logic [7:0]           chr;
    logic                 cvalid;
    logic                 last;
    logic [5:0]           kind;
    logic [LINE_BITS-1:0] line;
  } tok_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [S_DATA_W-1:0] s_data = '0;
  logic                s_last = 1'b0;
  logic                s_user = 1'b0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [M_DATA_W-1:0] m_data;
  logic                m_last;
  logic [M_USER_W-1:0] m_user;

  src_char_t char_q[$];       // characters waiting to be offered
  src_char_t cur_char;        // character currently on the slave channel
  tok_item_t token_fifo[$];   // token items predicted but not yet received
  logic [7:0] line_buf[$];    // text of the source line under construction

  int  send_idle_pct = 11;
  int  recv_idle_pct = 69;
  logic rx_hold = 1'b0;
  logic hold_go = 1'b0;
  int  stim_cnt = 0;
  int  err_cnt = 0;
  int  cycle_cnt = 0;

  string op_pairs[8] = '{"==", "!=", "<<", ">>", ">=", "<=", "&&", "||"};
  string kw_words[10] = '{"true", "false", "tru", "fals", "truex", "falsee",
                          "t", "xtrue", "trUe", "f"};

  // Lexer state as the model sees it.
  logic [2:0]           lx_mode = M_IDLE;
  logic [7:0]           lx_held = '0;
  logic [LINE_BITS-1:0] lx_start = '0;
  logic                 lx_dot = 1'b0;
  logic [2:0]           lx_wcnt = '0;
  logic [1:0]           lx_kmatch = 2'b11;

  script_lexer_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .m_axis_tuser_o  (m_user)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Lexer model
  // --------------------------------------------------------------------------

  // Operator kind of a single character, or -1 if it is no operator.
  function automatic int op_single_kind(logic [7:0] c);
    case (c)
      "{":     return OP_LBRACE;
      "}":     return OP_RBRACE;
      "(":     return OP_LPAREN;
      ")":     return OP_RPAREN;
      ",":     return OP_COMMA;
      ";":     return OP_SEMI;
      "=":     return OP_ASSIGN;
      "+":     return OP_PLUS;
      "-":     return OP_MINUS;
      "*":     return OP_STAR;
      "/":     return OP_SLASH;
      "%":     return OP_PCT;
      "&":     return OP_AMP;
      "|":     return OP_BAR;
      "!":     return OP_BANG;
      "^":     return OP_CARET;
      "<":     return OP_LT;
      ">":     return OP_GT;
      default: return -1;
    endcase
  endfunction

  function automatic int op_pair_kind(logic [7:0] a, logic [7:0] b);
    if (a == "=" && b == "=") return OP_EQEQ;
    if (a == "!" && b == "=") return OP_NE;
    if (a == "<" && b == "<") return OP_SHL;
    if (a == ">" && b == ">") return OP_SHR;
    if (a == ">" && b == "=") return OP_GE;
    if (a == "<" && b == "=") return OP_LE;
    if (a == "&" && b == "&") return OP_LAND;
    if (a == "|" && b == "|") return OP_LOR;
    return -1;
  endfunction

  // True for the first character of some two-character operator.
  function automatic logic pairable(logic [7:0] c);
    return c == "=" || c == "!" || c == "<" || c == ">" || c == "&" || c == "|";
  endfunction

  function automatic logic blank_char(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic logic num_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || c == CH_MINUS || c == CH_X || c == CH_DOT;
  endfunction

  // Replacement of an escaped character, or -1 if the backslash is kept.
  function automatic int esc_replace(logic [7:0] c);
    case (c)
      CH_BSLASH: return CH_BSLASH;
      CH_N:      return CH_LF;
      CH_T:      return CH_TAB;
      CH_DQUOTE: return CH_DQUOTE;
      CH_SQUOTE: return CH_SQUOTE;
      default:   return -1;
    endcase
  endfunction

  function automatic void push_tok(logic [7:0] ch, logic cv, logic last,
                                   logic [5:0] kind, logic [LINE_BITS-1:0] ln);
    tok_item_t t;
    t.chr    = ch;
    t.cvalid = cv;
    t.last   = last;
    t.kind   = last ? kind : '0;
    t.line   = ln;
    token_fifo.push_back(t);
  endfunction

  function automatic void reset_token();
    lx_mode   = M_IDLE;
    lx_held   = '0;
    lx_dot    = 1'b0;
    lx_wcnt   = '0;
    lx_kmatch = 2'b11;
  endfunction

  function automatic void end_of_source();
    push_tok(8'h00, 1'b0, 1'b1, K_NULL, '1);
    reset_token();
    lx_start = '0;
  endfunction

  // Narrows the keyword candidates by one more word character.
  function automatic void kw_step(logic [7:0] c);
    logic t_ok;
    logic f_ok;
    case (lx_wcnt)
      3'd0: begin
        t_ok = (c == "t");
        f_ok = (c == "f");
      end
      3'd1: begin
        t_ok = (c == "r");
        f_ok = (c == "a");
      end
      3'd2: begin
        t_ok = (c == "u");
        f_ok = (c == "l");
      end
      3'd3: begin
        t_ok = (c == "e");
        f_ok = (c == "s");
      end
      3'd4: begin
        t_ok = 1'b0;
        f_ok = (c == "e");
      end
      default: begin
        t_ok = 1'b0;
        f_ok = 1'b0;
      end
    endcase
    if (!t_ok) lx_kmatch[0] = 1'b0;
    if (!f_ok) lx_kmatch[1] = 1'b0;
    if (lx_wcnt < 3'd7) lx_wcnt = lx_wcnt + 3'd1;
  endfunction

  function automatic logic [5:0] word_kind_now();
    if ((lx_kmatch[0] && lx_wcnt == 3'd4) || (lx_kmatch[1] && lx_wcnt == 3'd5)) begin
      return K_BOOL;
    end
    return K_WORD;
  endfunction

  // A character seen between tokens.
  function automatic void token_start(logic [7:0] c, logic le, logic [LINE_BITS-1:0] ln);
    int k;
    k = op_single_kind(c);
    if (c == CH_NUL) begin
      end_of_source();
    end else if (c == CH_HASH) begin
      if (!le) lx_mode = M_COMMENT;
    end else if (!blank_char(c)) begin
      lx_start = ln;
      if (k >= 0) begin
        if (pairable(c)) begin
          lx_mode = M_OPHELD;
          lx_held = c;
        end else begin
          push_tok(c, 1'b1, 1'b1, 6'(k), ln);
        end
      end else if (num_char(c)) begin
        lx_mode = M_NUM;
        lx_dot  = (c == CH_DOT);
        push_tok(c, 1'b1, 1'b0, '0, ln);
      end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
        lx_mode = M_STR;
        lx_held = c;
      end else begin
        lx_mode   = M_WORD;
        lx_wcnt   = '0;
        lx_kmatch = 2'b11;
        kw_step(c);
        push_tok(c, 1'b1, 1'b0, '0, ln);
      end
    end
  endfunction

  function automatic void string_byte(logic [7:0] c);
    if (c == lx_held) begin
      push_tok(8'h00, 1'b0, 1'b1, K_STRING, lx_start);
      reset_token();
    end else if (c == CH_BSLASH) begin
      lx_mode = M_ESC;
    end else begin
      push_tok(c, 1'b1, 1'b0, '0, lx_start);
    end
  endfunction

  // Predicts the token items caused by one accepted character.
  function automatic void lex_char(src_char_t it);
    int r;
    logic [5:0] nk;
    if (it.se) begin
      // End of source: finish whatever token is open, then the null token.
      case (lx_mode)
        M_OPHELD: push_tok(lx_held, 1'b1, 1'b1, 6'(op_single_kind(lx_held)), lx_start);
        M_NUM:    push_tok(8'h00, 1'b0, 1'b1, lx_dot ? K_FLOAT : K_INT, lx_start);
        M_NUMBAD: push_tok(8'h00, 1'b0, 1'b1, K_NUMERR, lx_start);
        M_ESC: begin
          push_tok(CH_BSLASH, 1'b1, 1'b0, '0, lx_start);
          push_tok(8'h00, 1'b0, 1'b1, K_UNTERM, lx_start);
        end
        M_STR:    push_tok(8'h00, 1'b0, 1'b1, K_UNTERM, lx_start);
        M_WORD:   push_tok(8'h00, 1'b0, 1'b1, word_kind_now(), lx_start);
        default: ;
      endcase
      end_of_source();
    end else begin
      case (lx_mode)
        M_IDLE: token_start(it.chr, it.le, it.line);
        M_COMMENT: begin
          if (it.le) lx_mode = M_IDLE;
        end
        M_OPHELD: begin
          r = op_pair_kind(lx_held, it.chr);
          if (r >= 0) begin
            push_tok(lx_held, 1'b1, 1'b0, '0, lx_start);
            push_tok(it.chr, 1'b1, 1'b1, 6'(r), lx_start);
            reset_token();
          end else begin
            push_tok(lx_held, 1'b1, 1'b1, 6'(op_single_kind(lx_held)), lx_start);
            reset_token();
            token_start(it.chr, it.le, it.line);
          end
        end
        M_NUM, M_NUMBAD: begin
          if (num_char(it.chr)) begin
            if (it.chr == CH_DOT) begin
              if (lx_dot) lx_mode = M_NUMBAD;
              lx_dot = 1'b1;
            end
            push_tok(it.chr, 1'b1, 1'b0, '0, lx_start);
          end else begin
            nk = (lx_mode == M_NUMBAD) ? K_NUMERR : (lx_dot ? K_FLOAT : K_INT);
            push_tok(8'h00, 1'b0, 1'b1, nk, lx_start);
            reset_token();
            token_start(it.chr, it.le, it.line);
          end
        end
        M_STR: string_byte(it.chr);
        M_ESC: begin
          r = esc_replace(it.chr);
          lx_mode = M_STR;
          if (r >= 0) begin
            push_tok(8'(r), 1'b1, 1'b0, '0, lx_start);
          end else begin
            push_tok(CH_BSLASH, 1'b1, 1'b0, '0, lx_start);
            string_byte(it.chr);
          end
        end
        default: begin
          // Inside a word. Quotes and digits keep the word going.
          if (blank_char(it.chr) || it.chr == CH_HASH || it.chr == CH_NUL ||
              op_single_kind(it.chr) >= 0) begin
            push_tok(8'h00, 1'b0, 1'b1, word_kind_now(), lx_start);
            reset_token();
            token_start(it.chr, it.le, it.line);
          end else begin
            kw_step(it.chr);
            push_tok(it.chr, 1'b1, 1'b0, '0, lx_start);
          end
        end
      endcase
    end
  endfunction

  // --------------------------------------------------------------------------
  // Source generation
  // --------------------------------------------------------------------------

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  task automatic add_text(string t);
    for (int i = 0; i < t.len(); i++) line_buf.push_back(t[i]);
  endtask

  task automatic push_item(logic [7:0] chr, logic le, logic se, logic [LINE_BITS-1:0] ln);
    src_char_t it;
    it.chr  = chr;
    it.le   = le;
    it.se   = se;
    it.line = ln;
    char_q.push_back(it);
    stim_cnt++;
  endtask

  // Moves the line under construction into the character queue. The line-end
  // mark goes on its last character only when the line is complete.
  task automatic flush_line(logic [LINE_BITS-1:0] ln, logic complete);
    for (int i = 0; i < line_buf.size(); i++) begin
      push_item(line_buf[i], complete && (i == line_buf.size() - 1), 1'b0, ln);
    end
    line_buf.delete();
  endtask

  // An end-of-source transaction; its character and line carry no meaning.
  task automatic push_end();
    push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1,
              16'($urandom_range(0, 65535)));
  endtask

  task automatic gen_string(logic closed);
    logic [7:0] q;
    q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
    line_buf.push_back(q);
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 5))
        0, 1: line_buf.push_back(pick("abcXYZ 09 #"));
        2: begin
          line_buf.push_back(CH_BSLASH);
          line_buf.push_back(pick("\\nt\"'"));
        end
        3: begin
          // A backslash that is no escape stays in the text.
          line_buf.push_back(CH_BSLASH);
          line_buf.push_back(pick("qa0 ;"));
        end
        4: line_buf.push_back((q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE);
        default: line_buf.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    if (closed) line_buf.push_back(q);
  endtask

  task automatic gen_word();
    int n;
    n = $urandom_range(1, 9);
    line_buf.push_back(pick("abcdefghijklmnopqrstuvwyzABCDEFGHIJKLMNOPQRSTUVWXYZ_@$?:[]`~\\"));
    repeat (n - 1) begin
      if ($urandom_range(0, 5) == 0) begin
        line_buf.push_back(8'($urandom_range(128, 255)));
      end else begin
        line_buf.push_back(pick("abcdefghijklmnopqrstuvwxyzTRUEFALSE_0123456789'\"@"));
      end
    end
  endtask

  task automatic gen_token();
    case ($urandom_range(0, 11))
      0, 1: line_buf.push_back(pick("{}(),;=+-*/%&|!^<>"));
      2: add_text(op_pairs[$urandom_range(0, 7)]);
      3: begin
        if ($urandom_range(0, 3) == 0) add_text("0x");
        repeat ($urandom_range(1, 4)) line_buf.push_back(pick("0123456789"));
        if ($urandom_range(0, 3) == 0) add_text("-7");
      end
      4: begin
        repeat ($urandom_range(0, 3)) line_buf.push_back(pick("0123456789"));
        line_buf.push_back(CH_DOT);
        repeat ($urandom_range(0, 3)) line_buf.push_back(pick("0123456789"));
      end
      5: begin
        // Two or more dots make a malformed number.
        line_buf.push_back(pick("0123456789"));
        repeat ($urandom_range(2, 3)) begin
          line_buf.push_back(CH_DOT);
          line_buf.push_back(pick("0123456789x"));
        end
      end
      6, 7: gen_string(1'b1);
      8: add_text(kw_words[$urandom_range(0, 9)]);
      default: gen_word();
    endcase
  endtask

  // A source of one or two lines, at times with a further short line, closed by an end of source.
  task automatic gen_source();
    logic [LINE_BITS-1:0] ln;
    ln = $urandom_range(0, 65535);
    repeat ($urandom_range(1, 2)) begin
      repeat ($urandom_range(1, 3)) begin
        gen_token();
        case ($urandom_range(0, 4))
          0: ;
          1, 2: line_buf.push_back(CH_SPACE);
          3: line_buf.push_back(CH_TAB);
          default: add_text("  \t");
        endcase
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          line_buf.push_back(CH_HASH);
          repeat ($urandom_range(0, 4)) line_buf.push_back(pick("c =\"x"));
        end
        2: line_buf.push_back(CH_HASH);
        default: ;
      endcase
      flush_line(ln, 1'b1);
      ln = ln + LINE_BITS'($urandom_range(1, 3));
    end
    case ($urandom_range(0, 9))
      0: begin
        // The source stops inside a string.
        gen_string(1'b0);
        if ($urandom_range(0, 1)) line_buf.push_back(CH_BSLASH);
        flush_line(ln, 1'b0);
        push_end();
      end
      1: begin
        // A NUL byte ends the source when it falls between tokens.
        line_buf.push_back(CH_NUL);
        flush_line(ln, 1'($urandom_range(0, 1)));
      end
      2: begin
        // The last line stops without its line-end mark.
        gen_token();
        flush_line(ln, 1'b0);
        push_end();
      end
      default: push_end();
    endcase
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 6)) begin
      push_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                $urandom_range(0, 15) == 0, 16'($urandom_range(0, 65535)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued characters on the slave channel. The model runs on
  // each character in the cycle its transaction completes.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid  <= 1'b0;
      s_data   <= '0;
      s_last   <= 1'b0;
      s_user   <= 1'b0;
      reset_token();
      lx_start = '0;
    end else begin
      if (s_valid && s_ready) lex_char(cur_char);
      if (!s_valid || s_ready) begin
        if (char_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_char = char_q.pop_front();
          s_valid <= 1'b1;
          s_data  <= S_DATA_W'({cur_char.line, cur_char.chr});
          s_last  <= cur_char.le;
          s_user  <= cur_char.se;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness: random idling, forced low during the long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Long receiver stall so that the result register fills and the lexer
  // stops taking characters while the driver keeps offering them.
  initial begin : rx_backpressure
    while (!hold_go) @(negedge clk_i);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    rx_hold = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Monitor: every completed master transaction is checked against the
  // oldest predicted token item.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    tok_item_t got;
    tok_item_t want;
    if (rst_ni && m_valid && m_ready) begin
      got.chr    = m_data[7:0];
      got.line   = m_data[8 +: LINE_BITS];
      got.last   = m_last;
      got.cvalid = m_user[0];
      got.kind   = m_user[6:1];
      if (token_fifo.size() == 0) begin
        if (err_cnt < 10) begin
          $display("ERROR: unexpected token item chr=%h cv=%b last=%b kind=%0d line=%0d",
                   got.chr, got.cvalid, got.last, got.kind, got.line);
        end
        err_cnt++;
      end else begin
        want = token_fifo.pop_front();
        if (got.chr !== want.chr || got.cvalid !== want.cvalid ||
            got.last !== want.last || got.kind !== want.kind || got.line !== want.line) begin
          if (err_cnt < 10) begin
            $display("ERROR: token item mismatch at %0t", $realtime);
            $display("  expected chr=%h cv=%b last=%b kind=%0d line=%0d",
                     want.chr, want.cvalid, want.last, want.kind, want.line);
            $display("  actual   chr=%h cv=%b last=%b kind=%0d line=%0d",
                     got.chr, got.cvalid, got.last, got.kind, got.line);
          end
          err_cnt++;
        end
      end
    end
  end

  // Run limit, far above the slowest correct run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("ERROR: run limit of %0d cycles reached, %0d token items outstanding",
               CYCLE_LIMIT, token_fifo.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int goal;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Boolean word cut short by an operator, a two-character operator, and a
    // number that picks up a second dot and runs on across the line join.
    add_text("true>=.5.");
    flush_line(16'h0000, 1'b1);
    // The malformed number ends at a hash, which then skips its line.
    add_text("2#q");
    flush_line(16'hFFFF, 1'b1);
    // Kept backslash, escaped quote, an empty string, then a word that starts
    // with a byte of all ones and is ended by the end of source.
    add_text("\"\\q\\\"\"''");
    line_buf.push_back(8'hFF);
    flush_line(16'h00FF, 1'b0);
    push_end();
    // Unterminated string with a pending backslash.
    add_text("'z\\");
    flush_line(16'h1234, 1'b0);
    push_end();
    // NUL between tokens ends the source.
    line_buf.push_back(CH_NUL);
    flush_line(16'h0001, 1'b1);
    // A number that starts with x, then an operator held at the end of source.
    add_text("x1-&");
    flush_line(16'h8000, 1'b0);
    push_end();

    // Three random phases with different idling profiles. The long receiver
    // hold-off runs in the last phase, where nothing else idles.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 11;
          recv_idle_pct = 69;
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct = 11;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      goal = stim_cnt + ITEMS_PER_PHASE;
      while (stim_cnt < goal) begin
        if ($urandom_range(0, 9) < 8) gen_source();
        else gen_noise();
      end
      if (ph == 2) hold_go = 1'b1;
      while (char_q.size() != 0 || s_valid) @(negedge clk_i);
    end

    while (token_fifo.size() != 0) @(negedge clk_i);
    // Let any stray result item show up before the verdict.
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
